>>> rtl/core/set_assoc_cache_lru_sim_assert.svh
// Assertion macros for the cache simulator checker.
`ifndef SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH
`define SET_ASSOC_CACHE_LRU_SIM_ASSERT_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define SACL_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("cache simulator assertion failed");

// Next-cycle implication.
`define SACL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("cache simulator assertion failed");

`endif

>>> rtl/core/sacl_pkg.sv
// ----------------------------------------------------------------------------
// sacl_pkg
// Types, codes and defaults shared by the cache simulator and its checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sacl_pkg;

  localparam int MAX_SET_BITS_DEF = 6;
  localparam int MAX_WAYS_DEF     = 8;
  localparam int AGE_WIDTH_DEF    = 32;

  localparam int ADDR_W  = 64;
  localparam int TAG_W   = 63;
  localparam int STAMP_W = 64;
  localparam int CNT_W   = 32;
  localparam int CFG_W   = 6;

  // Record actions
  localparam logic [1:0] ACT_INSTR  = 2'd0;
  localparam logic [1:0] ACT_LOAD   = 2'd1;
  localparam logic [1:0] ACT_STORE  = 2'd2;
  localparam logic [1:0] ACT_MODIFY = 2'd3;

  // Access outcomes
  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_FILL  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_SET_BITS   = 2'd0;
  localparam logic [1:0] REG_BLOCK_BITS = 2'd1;
  localparam logic [1:0] REG_WAYS       = 2'd2;

  typedef struct packed {
    logic [1:0]        action;
    logic [ADDR_W-1:0] address;
  } in_data_t;

  typedef struct packed {
    logic [1:0]       outcome;
    logic             is_last;
    logic [CNT_W-1:0] hit_total;
    logic [CNT_W-1:0] miss_total;
    logic [CNT_W-1:0] eviction_total;
  } out_data_t;

  // One cache line; stamp is the record number of its last access
  typedef struct packed {
    logic               valid;
    logic [TAG_W-1:0]   tag;
    logic [STAMP_W-1:0] stamp;
  } line_t;

endpackage

>>> rtl/core/set_assoc_cache_lru_sim.sv
// ----------------------------------------------------------------------------
// set_assoc_cache_lru_sim
// Set-associative cache simulator with LRU replacement and hit, miss and
// eviction counters. One set row is read, updated and written back per data record.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  in_     | input     | in_valid / in_stall   | in_data_t  (action, address)
//  out_    | output    | out_valid / out_stall | out_data_t (outcome, totals)
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
// Load or store: row read on accept, then evaluate and write back. Modify: the
// same, then a second access that is a fixed hit. Instruction: no lookup. Ages
// are kept as record stamps. After reset a clearing pass over all 2**MAX_SET_BITS
// sets holds in_stall high. A stalled output holds the block in its evaluate or
// second-access state. The set memory is used as a single port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module set_assoc_cache_lru_sim
  import sacl_pkg::*;
#(
  parameter int MAX_SET_BITS = MAX_SET_BITS_DEF,
  parameter int MAX_WAYS     = MAX_WAYS_DEF,
  parameter int AGE_WIDTH    = AGE_WIDTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  in_data_t        in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output out_data_t       out_data,
  input  logic            cfg_we,
  input  logic [1:0]      cfg_index,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int NUM_SETS = 1 << MAX_SET_BITS;
  localparam int SB_W     = $clog2(MAX_SET_BITS + 1);
  localparam int WC_W     = $clog2(MAX_WAYS + 1);
  localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;

  typedef enum logic [3:0] {
    S_CLEAR  = 4'b0001,
    S_IDLE   = 4'b0010,
    S_EVAL   = 4'b0100,
    S_SECOND = 4'b1000
  } state_t;

  typedef logic [MAX_WAYS-1:0][$bits(line_t)-1:0] row_t;

  state_t                  state_r, state_nxt;
  logic [2:0]              set_bits_r;
  logic [5:0]              block_bits_r;
  logic [3:0]              ways_r;
  logic [MAX_SET_BITS-1:0] clr_idx_r;
  logic [STAMP_W-1:0]      now_r;
  logic [CNT_W-1:0]        hit_r, miss_r, evict_r;
  logic                    out_valid_r;
  out_data_t               out_data_r;
  row_t                    rd_row_r;
  logic [MAX_SET_BITS-1:0] set_r;
  logic [TAG_W-1:0]        tag_r;
  logic                    modify_r;

  row_t mem [NUM_SETS];

  // Effective geometry
  logic [SB_W-1:0]         s_eff;
  logic [5:0]              b_eff;
  logic [WC_W-1:0]         ways_eff;
  logic [6:0]              shift;
  logic [ADDR_W-1:0]       addr_sh;
  logic [MAX_SET_BITS-1:0] set_mask, set_idx;
  logic [TAG_W-1:0]        tag_in;

  always_comb begin
    if (set_bits_r == 3'd0) s_eff = SB_W'(1);
    else if (32'(set_bits_r) > MAX_SET_BITS) s_eff = SB_W'(MAX_SET_BITS);
    else s_eff = SB_W'(set_bits_r);
    b_eff = (block_bits_r == 6'd0) ? 6'd1 : block_bits_r;
    if (ways_r == 4'd0) ways_eff = WC_W'(1);
    else if (32'(ways_r) > MAX_WAYS) ways_eff = WC_W'(MAX_WAYS);
    else ways_eff = WC_W'(ways_r);
    shift    = 7'(s_eff) + 7'(b_eff);
    addr_sh  = in_data.address >> b_eff;
    set_mask = ~({MAX_SET_BITS{1'b1}} << s_eff);
    set_idx  = addr_sh[MAX_SET_BITS-1:0] & set_mask;
    tag_in   = (shift >= 7'd64) ? '0 : TAG_W'(in_data.address >> shift);
  end

  logic in_acc, out_free;
  assign in_acc   = in_valid && (state_r == S_IDLE);
  assign out_free = !out_valid_r || !out_stall;

  // Lookup on the row read back from memory
  logic                 hit, free_found, have_v;
  logic [WAY_W-1:0]     hit_w, free_w, vic_w, sel_w;
  logic [AGE_WIDTH-1:0] best, age;
  logic [STAMP_W-1:0]   diff;
  line_t                ln;
  line_t                wr_line;
  row_t                 wr_row;
  logic [1:0]           outcome;

  always_comb begin
    hit = 1'b0; free_found = 1'b0; have_v = 1'b0;
    hit_w = '0; free_w = '0; vic_w = '0; best = '0;
    for (int w = 0; w < MAX_WAYS; w++) begin
      ln   = line_t'(rd_row_r[w]);
      diff = now_r - ln.stamp;
      age  = (|diff[STAMP_W-1:AGE_WIDTH]) ? {AGE_WIDTH{1'b1}} : diff[AGE_WIDTH-1:0];
      if (WC_W'(w) < ways_eff) begin
        if (ln.valid && ln.tag == tag_r && !hit) begin
          hit = 1'b1; hit_w = WAY_W'(w);
        end
        if (!ln.valid && !free_found) begin
          free_found = 1'b1; free_w = WAY_W'(w);
        end
        if (ln.valid && (!have_v || age > best)) begin
          have_v = 1'b1; best = age; vic_w = WAY_W'(w);
        end
      end
    end
    if (hit) begin
      outcome = OUT_HIT; sel_w = hit_w;
    end else if (free_found) begin
      outcome = OUT_FILL; sel_w = free_w;
    end else begin
      outcome = OUT_EVICT; sel_w = vic_w;
    end
    wr_line.valid = 1'b1;
    wr_line.tag   = tag_r;
    wr_line.stamp = now_r;
    wr_row        = rd_row_r;
    wr_row[sel_w] = wr_line;
  end

  // Set memory: clearing pass, read on accept, write back after lookup
  always_ff @(posedge clk) begin
    if (state_r == S_CLEAR) mem[clr_idx_r] <= '0;
    else if (state_r == S_EVAL && out_free) mem[set_r] <= wr_row;
    if (in_acc) rd_row_r <= mem[set_idx];
  end

  // Request fields held for the lookup
  always_ff @(posedge clk) begin
    if (in_acc) begin
      set_r    <= set_idx;
      tag_r    <= tag_in;
      modify_r <= (in_data.action == ACT_MODIFY);
    end
  end

  // State sequencing
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_CLEAR:  if (&clr_idx_r) state_nxt = S_IDLE;
      S_IDLE:   if (in_acc && in_data.action != ACT_INSTR) state_nxt = S_EVAL;
      S_EVAL:   if (out_free) state_nxt = modify_r ? S_SECOND : S_IDLE;
      S_SECOND: if (out_free) state_nxt = S_IDLE;
      default:  state_nxt = S_CLEAR;
    endcase
  end

  // Control, counters and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_CLEAR;
      clr_idx_r    <= '0;
      set_bits_r   <= 3'd4;
      block_bits_r <= 6'd4;
      ways_r       <= 4'd1;
      now_r        <= '0;
      hit_r        <= '0;
      miss_r       <= '0;
      evict_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_idx_r <= clr_idx_r + 1'b1;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SET_BITS:   set_bits_r   <= cfg_wdata[2:0];
          REG_BLOCK_BITS: block_bits_r <= cfg_wdata;
          REG_WAYS:       ways_r       <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      // drop the result once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && state_r != S_EVAL && state_r != S_SECOND)
        out_valid_r <= 1'b0;
      // instruction records age at once; others at their last access
      if (in_acc && in_data.action == ACT_INSTR) now_r <= now_r + 1'b1;
      if (state_r == S_EVAL && out_free) begin
        out_valid_r                 <= 1'b1;
        out_data_r.outcome          <= outcome;
        out_data_r.is_last          <= !modify_r;
        out_data_r.hit_total        <= hit_r + CNT_W'(outcome == OUT_HIT);
        out_data_r.miss_total       <= miss_r + CNT_W'(outcome != OUT_HIT);
        out_data_r.eviction_total   <= evict_r + CNT_W'(outcome == OUT_EVICT);
        hit_r   <= hit_r + CNT_W'(outcome == OUT_HIT);
        miss_r  <= miss_r + CNT_W'(outcome != OUT_HIT);
        evict_r <= evict_r + CNT_W'(outcome == OUT_EVICT);
        if (!modify_r) now_r <= now_r + 1'b1;
      end
      if (state_r == S_SECOND && out_free) begin
        out_valid_r               <= 1'b1;
        out_data_r.outcome        <= OUT_HIT;
        out_data_r.is_last        <= 1'b1;
        out_data_r.hit_total      <= hit_r + 1'b1;
        out_data_r.miss_total     <= miss_r;
        out_data_r.eviction_total <= evict_r;
        hit_r <= hit_r + 1'b1;
        now_r <= now_r + 1'b1;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

>>> rtl/core/sacl_checker.sv
// ----------------------------------------------------------------------------
// sacl_checker
// Port-level checks on the cache simulator, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "set_assoc_cache_lru_sim_assert.svh"

module sacl_checker
  import sacl_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input in_data_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input out_data_t out_data
);

  logic in_acc, out_acc;
  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Stalled result stays offered and unchanged
  `SACL_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid)
  `SACL_ASSERT_NEXT(a_out_stable, clk, rst_n, out_valid && out_stall, $stable(out_data))
  // First result of a modify is followed at once by a hit marked last
  `SACL_ASSERT_NEXT(a_modify_second, clk, rst_n, out_acc && !out_data.is_last,
                    out_valid && out_data.is_last && out_data.outcome == OUT_HIT)
  // A data access occupies the block for at least the lookup cycle
  `SACL_ASSERT_NEXT(a_access_busy, clk, rst_n, in_acc && in_data.action != ACT_INSTR,
                    in_stall)

endmodule

bind set_assoc_cache_lru_sim sacl_checker u_sacl_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
